>>> rtl/mlt_pkg.sv
// shared types and constants for the mac learning table
package mlt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 256;
  localparam int PORT_COUNT    = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // field widths
  localparam int ADDR_W     = 48;
  localparam int PORT_W     = 4;
  localparam int TIME_W     = 48;
  localparam int COUNT_W    = 9;
  localparam int MAX_W      = 9;
  localparam int AGE_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = MAX_W'(256);
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST   = AGE_W'(300);
  localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};

  typedef enum logic [0:0] {
    OP_LEARN  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ENTRIES = 1'b0,
    REG_AGE_LIMIT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  // one stored table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  // sequencer to store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic             set_vld;
    logic             clr_vld;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
  } store_cmd_t;

  // store to sequencer, valid in the cycle after a read
  typedef struct packed {
    logic   rd_vld;
    entry_t rd_entry;
  } store_rsp_t;

endpackage

>>> rtl/mlt_req_if.sv
// request channel: operation, address, port and time
interface mlt_req_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [mlt_pkg::ADDR_W-1:0]  mac_address;
  logic [mlt_pkg::PORT_W-1:0]  port_number;
  logic [mlt_pkg::TIME_W-1:0]  now;

  modport source (output valid, output operation, output mac_address,
                  output port_number, output now, input ready);
  modport sink (input valid, input operation, input mac_address,
                input port_number, input now, output ready);
endinterface

>>> rtl/mlt_rsp_if.sv
// response channel: hit, port and entry count
interface mlt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [mlt_pkg::PORT_W-1:0]  found_port;
  logic [mlt_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, output hit, output found_port,
                  output entry_count, input ready);
  modport sink (input valid, input hit, input found_port,
                input entry_count, output ready);
endinterface

>>> rtl/mlt_store.sv
// entry memory with per-slot valid flops and registered read
module mlt_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlt_pkg::store_cmd_t cmd_i,
  output mlt_pkg::store_rsp_t rsp_o
);

  mlt_pkg::entry_t mem [mlt_pkg::TABLE_ENTRIES];
  logic [mlt_pkg::TABLE_ENTRIES-1:0] vld_q;
  mlt_pkg::entry_t rd_entry_q;
  logic            rd_vld_q;

  // entry write
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_idx] <= cmd_i.wr_entry;
    end
  end

  // registered read of entry and its valid flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_entry_q <= mem[cmd_i.rd_idx];
      rd_vld_q   <= vld_q[cmd_i.rd_idx];
    end
  end

  // valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.set_vld) begin
      vld_q[cmd_i.wr_idx] <= 1'b1;
    end else if (cmd_i.clr_vld) begin
      vld_q[cmd_i.wr_idx] <= 1'b0;
    end
  end

  assign rsp_o.rd_vld   = rd_vld_q;
  assign rsp_o.rd_entry = rd_entry_q;

endmodule

>>> rtl/mlt_seq.sv
// scan sequencer: one slot compared per cycle, then update and respond
module mlt_seq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mlt_req_if.sink                            req_i,
  mlt_rsp_if.source                          rsp_o,
  input  logic                               cfg_we_i,
  input  logic [mlt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output mlt_pkg::store_cmd_t                cmd_o,
  input  mlt_pkg::store_rsp_t                srsp_i
);

  mlt_pkg::state_e state_q, state_d;

  // configuration
  logic [mlt_pkg::MAX_W-1:0] max_q;
  logic [mlt_pkg::AGE_W-1:0] age_q;

  // request capture
  logic                        op_q;
  logic [mlt_pkg::ADDR_W-1:0]  addr_q;
  logic [mlt_pkg::PORT_W-1:0]  port_q;
  logic [mlt_pkg::TIME_W-1:0]  now_q;
  logic [mlt_pkg::TIME_W-1:0]  exp_q;
  logic [mlt_pkg::TIME_W:0]    exp_sum;

  // scan state
  logic [mlt_pkg::IDX_W-1:0]   idx_q;
  logic [mlt_pkg::IDX_W-1:0]   cmp_idx_q;
  logic                        pend_q;
  logic                        match_q;
  logic [mlt_pkg::IDX_W-1:0]   match_idx_q;
  logic [mlt_pkg::PORT_W-1:0]  match_port_q;
  logic [mlt_pkg::TIME_W-1:0]  match_exp_q;
  logic                        free_fnd_q;
  logic [mlt_pkg::IDX_W-1:0]   free_idx_q;
  logic [mlt_pkg::CNT_W-1:0]   live_q;

  // result register
  logic                        rsp_vld_q;
  logic                        rsp_hit_q;
  logic [mlt_pkg::PORT_W-1:0]  rsp_port_q;
  logic [mlt_pkg::COUNT_W-1:0] rsp_cnt_q;

  // decision terms
  logic accept, go, learn_ok, lookup, room, fresh;
  logic do_refresh, do_insert, do_expire, hit_d;
  logic [mlt_pkg::CNT_W-1:0] live_d;

  assign accept = req_i.valid && req_i.ready;

  assign learn_ok = (op_q == mlt_pkg::OP_LEARN) && (32'(port_q) < mlt_pkg::PORT_COUNT);
  assign lookup   = (op_q == mlt_pkg::OP_LOOKUP);
  assign room     = (32'(live_q) < 32'(max_q)) && free_fnd_q;
  assign fresh    = match_exp_q > now_q;

  assign do_refresh = learn_ok && match_q;
  assign do_insert  = learn_ok && !match_q && room;
  assign do_expire  = lookup && match_q && !fresh;
  assign hit_d      = do_refresh || do_insert || (lookup && match_q && fresh);

  // saturating expiry
  assign exp_sum = {1'b0, now_q} + (mlt_pkg::TIME_W + 1)'(age_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlt_pkg::ST_IDLE: begin
        if (req_i.valid) state_d = mlt_pkg::ST_SCAN;
      end
      mlt_pkg::ST_SCAN: begin
        if (idx_q == mlt_pkg::LAST_IDX) state_d = mlt_pkg::ST_DRAIN;
      end
      mlt_pkg::ST_DRAIN: begin
        state_d = mlt_pkg::ST_DECIDE;
      end
      mlt_pkg::ST_DECIDE: begin
        if (!rsp_vld_q || rsp_o.ready) state_d = mlt_pkg::ST_IDLE;
      end
      default: state_d = mlt_pkg::ST_IDLE;
    endcase
  end

  // outputs and store commands
  always_comb begin
    req_i.ready = 1'b0;
    go          = 1'b0;
    cmd_o       = '0;
    case (state_q)
      mlt_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      mlt_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      mlt_pkg::ST_DECIDE: begin
        go = !rsp_vld_q || rsp_o.ready;
      end
      default: begin
        go = 1'b0;
      end
    endcase
    cmd_o.rd_idx          = idx_q;
    cmd_o.wr_idx          = match_q ? match_idx_q : free_idx_q;
    cmd_o.wr_en           = go && (do_refresh || do_insert);
    cmd_o.set_vld         = go && do_insert;
    cmd_o.clr_vld         = go && do_expire;
    cmd_o.wr_entry.addr   = addr_q;
    cmd_o.wr_entry.port   = port_q;
    cmd_o.wr_entry.expiry = exp_q;
  end

  // live count after this request
  always_comb begin
    live_d = live_q;
    if (do_insert) begin
      live_d = live_q + mlt_pkg::CNT_W'(1);
    end else if (do_expire && (live_q != '0)) begin
      live_d = live_q - mlt_pkg::CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mlt_pkg::ST_IDLE;
      max_q      <= mlt_pkg::MAX_ENTRIES_RST;
      age_q      <= mlt_pkg::AGE_LIMIT_RST;
      idx_q      <= '0;
      pend_q     <= 1'b0;
      match_q    <= 1'b0;
      free_fnd_q <= 1'b0;
      live_q     <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= cmd_o.rd_en;

      // register writes
      if (cfg_we_i) begin
        case (mlt_pkg::cfg_reg_e'(cfg_idx_i))
          mlt_pkg::REG_MAX_ENTRIES: max_q <= cfg_data_i[mlt_pkg::MAX_W-1:0];
          mlt_pkg::REG_AGE_LIMIT:   age_q <= cfg_data_i[mlt_pkg::AGE_W-1:0];
          default: ;
        endcase
      end

      // scan index and match tracking
      if (accept) begin
        idx_q      <= '0;
        match_q    <= 1'b0;
        free_fnd_q <= 1'b0;
      end else begin
        if (cmd_o.rd_en) idx_q <= idx_q + mlt_pkg::IDX_W'(1);
        if (pend_q && srsp_i.rd_vld && (srsp_i.rd_entry.addr == addr_q)) match_q <= 1'b1;
        if (pend_q && !srsp_i.rd_vld) free_fnd_q <= 1'b1;
      end

      if (go) live_q <= live_d;

      // result transfer
      if (go) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.operation;
      addr_q <= req_i.mac_address;
      port_q <= req_i.port_number;
      now_q  <= req_i.now;
    end
    if (state_q == mlt_pkg::ST_SCAN) begin
      exp_q <= exp_sum[mlt_pkg::TIME_W] ? mlt_pkg::TIME_MAX : exp_sum[mlt_pkg::TIME_W-1:0];
    end
    cmp_idx_q <= idx_q;
    // first matching slot
    if (pend_q && !match_q && srsp_i.rd_vld && (srsp_i.rd_entry.addr == addr_q)) begin
      match_idx_q  <= cmp_idx_q;
      match_port_q <= srsp_i.rd_entry.port;
      match_exp_q  <= srsp_i.rd_entry.expiry;
    end
    // lowest free slot
    if (pend_q && !free_fnd_q && !srsp_i.rd_vld) begin
      free_idx_q <= cmp_idx_q;
    end
    if (go) begin
      rsp_hit_q  <= hit_d;
      rsp_port_q <= (lookup && match_q && fresh) ? match_port_q : '0;
      rsp_cnt_q  <= mlt_pkg::COUNT_W'(live_d);
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.found_port  = rsp_port_q;
  assign rsp_o.entry_count = rsp_cnt_q;

endmodule

>>> rtl/mac_learning_table_with_aging_top.sv
// mac learning table top level: sequencer and entry store
// requests: one at a time; each runs a scan of 256 slots, then drain, decide and idle before the next is taken
// the response register frees the request side while a result waits
// reset: valid flags, live count and handshake state cleared at once, no clearing pass
// reset: max_entries returns to 256 and age_limit to 300
module mac_learning_table_with_aging_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mlt_req_if.sink                        req_i,
  mlt_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [mlt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mlt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mlt_pkg::store_cmd_t cmd;
  mlt_pkg::store_rsp_t srsp;

  // sequencer with compare unit
  mlt_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_o      (cmd),
    .srsp_i     (srsp)
  );

  // entry storage
  mlt_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (srsp)
  );

endmodule

>>> rtl/mlt_checker.sv
// port-level checks for the mac learning table
module mlt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          rsp_hit_i,
  input logic [mlt_pkg::PORT_W-1:0]    rsp_found_port_i,
  input logic [mlt_pkg::COUNT_W-1:0]   rsp_entry_count_i
);

  // no second request right after a transfer
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken back to back");

  // a miss reports port zero
  a_miss_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |-> (rsp_found_port_i == '0))
    else $error("port reported on a miss");

  // count never exceeds the slot count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_entry_count_i) <= mlt_pkg::TABLE_ENTRIES))
    else $error("entry count above capacity");

  // stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_hit_i) && $stable(rsp_found_port_i) &&
       $stable(rsp_entry_count_i)))
    else $error("stalled response changed");

endmodule

bind mac_learning_table_with_aging_top mlt_checker u_mlt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_hit_i         (rsp_o.hit),
  .rsp_found_port_i  (rsp_o.found_port),
  .rsp_entry_count_i (rsp_o.entry_count)
);
